### design/tos_pkg.sv
// tos_pkg: types, constants and helper functions shared by the track order sorter.
// Used by tos_ctrl, tos_dp and track_order_sorter; depends on nothing.
package tos_pkg;

    localparam int TAG_W = 8;
    localparam int TRK_W = 16;
    localparam logic [TRK_W-1:0] MAX_PLAUS_RST = 16'd99;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [TRK_W-1:0] trk;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic ins_step;
        logic emit_start;
        logic emit_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stored;
        logic ins_done;
        logic emit_final;
    } stat_t;

    // true if an entry with track a plays after one with track b
    function automatic logic goes_after(input logic [TRK_W-1:0] a, input logic [TRK_W-1:0] b);
        logic res;
        if ((a != '0) && (b != '0))
            res = (a > b);
        else
            res = (a == '0) && (b != '0);
        return res;
    endfunction

endpackage

### design/tos_ctrl.sv
// tos_ctrl: sequencer for load, insertion walk and emission of the track order sorter.
// Depends on tos_pkg (state, command and status types).
module tos_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           is_last,
    input  tos_pkg::stat_t stat,
    output tos_pkg::cmd_t  cmd,
    output logic           busy
);

    tos_pkg::state_t state_reg;
    tos_pkg::state_t state_next;
    logic            last_reg;
    logic            last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tos_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            tos_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load  = 1'b1;
                    last_next = is_last;
                    if (stat.stored)
                        state_next = tos_pkg::ST_INSERT;
                    else if (is_last)
                    begin
                        // store full: nothing to insert, go straight to output
                        cmd.emit_start = 1'b1;
                        state_next     = tos_pkg::ST_EMIT;
                    end
                end
            end
            tos_pkg::ST_INSERT:
            begin
                cmd.ins_step = 1'b1;
                if (stat.ins_done)
                begin
                    if (last_reg)
                    begin
                        cmd.emit_start = 1'b1;
                        state_next     = tos_pkg::ST_EMIT;
                    end
                    else
                        state_next = tos_pkg::ST_IDLE;
                end
            end
            tos_pkg::ST_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (stat.emit_final)
                    state_next = tos_pkg::ST_FLUSH;
            end
            tos_pkg::ST_FLUSH:
            begin
                // final item is on the outputs this cycle
                state_next = tos_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tos_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/tos_dp.sv
// tos_dp: entry stores, album statistics, insertion walk and output registers.
// Depends on tos_pkg (entry, command and status types, goes_after).
module tos_dp
#(
    parameter int CAPACITY = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tos_pkg::cmd_t             cmd,
    output tos_pkg::stat_t            stat,
    input  logic [tos_pkg::TAG_W-1:0] song_tag,
    input  logic [tos_pkg::TRK_W-1:0] track_number,
    input  logic                      cfg_we,
    input  logic [tos_pkg::TRK_W-1:0] cfg_data,
    output logic                      result_strobe,
    output logic [tos_pkg::TAG_W-1:0] song_tag_res,
    output logic [tos_pkg::TRK_W-1:0] track_number_res,
    output logic                      is_last_res,
    output logic                      was_sorted
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // load order and sorted order copies of the album
    tos_pkg::entry_t ld_mem  [CAPACITY];
    tos_pkg::entry_t srt_mem [CAPACITY];

    tos_pkg::entry_t ld_q;
    tos_pkg::entry_t srt_q;
    tos_pkg::entry_t new_reg;

    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            num_reg;
    logic                     plaus_reg;
    logic [AW-1:0]            k_reg;
    logic [AW-1:0]            idx_reg;
    logic                     sorted_reg;
    logic                     out_valid_reg;
    logic                     out_last_reg;
    logic [tos_pkg::TRK_W-1:0] max_reg;

    logic                     full;
    logic                     shift;
    logic [AW-1:0]            cnt_a;
    logic [AW-1:0]            srt_raddr;
    logic                     srt_re;
    tos_pkg::entry_t          srt_wdata;
    tos_pkg::entry_t          in_entry;
    logic                     num_ok;

    assign full     = (cnt_reg == CW'(CAPACITY));
    assign cnt_a    = cnt_reg[AW-1:0];
    assign in_entry = '{tag: song_tag, trk: track_number};
    assign num_ok   = ({num_reg, 1'b0} >= {1'b0, cnt_reg});

    // walk continues while the stored neighbor belongs after the new entry
    assign shift     = (k_reg != '0) && tos_pkg::goes_after(srt_q.trk, new_reg.trk);
    assign srt_wdata = shift ? srt_q : new_reg;

    always_comb
    begin
        srt_re    = cmd.load || cmd.ins_step || cmd.emit_step;
        srt_raddr = k_reg - AW'(2);
        if (cmd.emit_step)
            srt_raddr = idx_reg;
        else if (cmd.load)
            srt_raddr = cnt_a - AW'(1);
    end

    assign stat.stored     = !full;
    assign stat.ins_done   = !shift;
    assign stat.emit_final = (CW'(idx_reg) == cnt_reg - CW'(1));

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
            ld_mem[cnt_a] <= in_entry;
        if (cmd.emit_step)
            ld_q <= ld_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_step)
            srt_mem[k_reg] <= srt_wdata;
        if (srt_re)
            srt_q <= srt_mem[srt_raddr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
            new_reg <= in_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            num_reg       <= '0;
            plaus_reg     <= 1'b0;
            k_reg         <= '0;
            idx_reg       <= '0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            max_reg       <= tos_pkg::MAX_PLAUS_RST;
        end
        else
        begin
            out_valid_reg <= cmd.emit_step;
            if (cfg_we)
                max_reg <= cfg_data;
            if (cmd.load && !full)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                k_reg   <= cnt_a;
                if (track_number != '0)
                begin
                    num_reg <= num_reg + CW'(1);
                    if (track_number <= max_reg)
                        plaus_reg <= 1'b1;
                end
            end
            if (cmd.ins_step && shift)
                k_reg <= k_reg - AW'(1);
            if (cmd.emit_start)
            begin
                sorted_reg <= plaus_reg && num_ok;
                idx_reg    <= '0;
            end
            if (cmd.emit_step)
            begin
                idx_reg      <= idx_reg + AW'(1);
                out_last_reg <= stat.emit_final;
                if (stat.emit_final)
                begin
                    // album done, next item opens a new one
                    cnt_reg   <= '0;
                    num_reg   <= '0;
                    plaus_reg <= 1'b0;
                end
            end
        end
    end

    assign result_strobe    = out_valid_reg;
    assign song_tag_res     = sorted_reg ? srt_q.tag : ld_q.tag;
    assign track_number_res = sorted_reg ? srt_q.trk : ld_q.trk;
    assign is_last_res      = out_last_reg;
    assign was_sorted       = sorted_reg;

endmodule

### design/track_order_sorter.sv
// track_order_sorter: top level of the album track order sorter.
// Depends on tos_pkg, tos_ctrl and tos_dp.
//
// Usage:
//   Input: an item (song_tag, track_number, is_last) is taken at a clock edge
//   with start high and busy low. Up to CAPACITY items per album are stored;
//   later ones are dropped but an is_last on them still ends the album.
//   Each stored item is placed into a sorted copy by an insertion walk that
//   moves one entry per cycle, and busy stays high until that walk ends;
//   the walk for the k-th stored item (k from 0) shifts at most k entries.
//   Output: after the last item, one result per stored entry appears on
//   consecutive cycles, each marked by a one-cycle result_strobe; the first
//   result follows the end of the insertion walk (or the dropped last item)
//   via the store read registers. is_last_res marks the final one and busy
//   falls in the cycle after that final result is shown. The receiver cannot stall.
//   Config: cfg_we/cfg_data write max_plausible_track (reset 99); write it
//   only while busy is low and no album is half loaded.
//   Reset clears counts and state; the stores need no clearing.
module track_order_sorter
#(
    parameter int CAPACITY = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [tos_pkg::TAG_W-1:0] song_tag,
    input  logic [tos_pkg::TRK_W-1:0] track_number,
    input  logic                      is_last,
    input  logic                      cfg_we,
    input  logic [tos_pkg::TRK_W-1:0] cfg_data,
    output logic                      result_strobe,
    output logic [tos_pkg::TAG_W-1:0] song_tag_res,
    output logic [tos_pkg::TRK_W-1:0] track_number_res,
    output logic                      is_last_res,
    output logic                      was_sorted
);

    tos_pkg::cmd_t  cmd;
    tos_pkg::stat_t stat;

    tos_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (is_last),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    tos_dp
    #(
        .CAPACITY (CAPACITY)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .song_tag         (song_tag),
        .track_number     (track_number),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .result_strobe    (result_strobe),
        .song_tag_res     (song_tag_res),
        .track_number_res (track_number_res),
        .is_last_res      (is_last_res),
        .was_sorted       (was_sorted)
    );

endmodule
